// File: src/modinv_pkg.sv
package modinv_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_DIV,
      ST_DIV_END,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic fast_step;
      logic div_start;
      logic div_step;
      logic div_finish;
      logic finalize;
   } cmd_type;

   typedef struct packed {
      logic r1_zero;
      logic q_small;
      logic div_last;
   } status_type;

endpackage

// File: src/modular_inverse_top.sv
// Modular inverse by the extended Euclidean algorithm.
// Input channel: req_valid / req_stall carry one item (req_value, req_modulus),
// both WORD_BITS-1 bits unsigned. Result channel: rsp_valid / rsp_stall carry
// rsp_inverse, the Bezout coefficient of the value with the modulus added once
// when negative; it is the true inverse when gcd is one. A zero modulus gives 1.
// One item is in flight at a time: req_stall is low only while idle.
// Each Euclid round with quotient 0 or 1 is a single step in ST_ROUND; a
// round with a larger quotient runs the shared restoring divider, one
// quotient bit per cycle, through ST_DIV and then ST_DIV_END. The divider
// loop also builds quotient times coefficient by shift-and-add.
// The result sits in an output register; while rsp_stall is high the item
// and rsp_valid hold, and no new item is taken.
// Reset (synchronous, active high) returns the controller to idle and drops
// rsp_valid; datapath registers are not cleared.
module modular_inverse_top import modinv_pkg::*; #(
   parameter int WORD_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [WORD_BITS-2:0] req_value,
   input  logic [WORD_BITS-2:0] req_modulus,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_BITS-2:0] rsp_inverse
);
   cmd_type    cmd;
   status_type status;

   // sequence the rounds and the divider
   modinv_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .status, .cmd
   );

   // hold remainders, coefficients and the divider state
   modinv_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
      .clock, .req_value, .req_modulus, .cmd, .status, .rsp_inverse
   );
endmodule

// File: src/modinv_datapath.sv
module modinv_datapath import modinv_pkg::*; #(
   parameter int WORD_BITS = 64
) (
   input  logic                   clock,
   input  logic [WORD_BITS-2:0]   req_value,
   input  logic [WORD_BITS-2:0]   req_modulus,
   input  cmd_type                cmd,
   output status_type             status,
   output logic [WORD_BITS-2:0]   rsp_inverse
);
   localparam int OpW  = WORD_BITS - 1;
   localparam int CntW = $clog2(WORD_BITS);

   logic [OpW-1:0]       r0_ff, r0_in, r1_ff, r1_in, m_ff, m_in;
   logic [OpW-1:0]       p_ff, p_in, d_ff, d_in, inv_ff, inv_in;
   logic [WORD_BITS-1:0] s0_ff, s0_in, s1_ff, s1_in, t_ff, t_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] pp, twice_r1, s_fix;
   logic                 qbit;

   always_comb begin
      twice_r1 = {r1_ff, 1'b0};
      pp       = {p_ff, d_ff[OpW-1]};
      qbit     = pp >= {1'b0, r1_ff};
      s_fix    = s0_ff[WORD_BITS-1] ? s0_ff + {1'b0, m_ff} : s0_ff;

      r0_in = r0_ff; r1_in = r1_ff; m_in = m_ff;
      s0_in = s0_ff; s1_in = s1_ff;
      p_in = p_ff; d_in = d_ff; t_in = t_ff; cnt_in = cnt_ff; inv_in = inv_ff;

      if (cmd.load) begin
         r0_in = req_value; r1_in = req_modulus; m_in = req_modulus;
         s0_in = WORD_BITS'(1); s1_in = '0;
      end
      if (cmd.fast_step) begin
         if (r0_ff < r1_ff) begin
            // quotient zero: swap
            r0_in = r1_ff; r1_in = r0_ff;
            s0_in = s1_ff; s1_in = s0_ff;
         end else begin
            // quotient one: subtract
            r0_in = r1_ff; r1_in = r0_ff - r1_ff;
            s0_in = s1_ff; s1_in = s0_ff - s1_ff;
         end
      end
      if (cmd.div_start) begin
         p_in = '0; d_in = r0_ff; t_in = '0; cnt_in = '0;
      end
      if (cmd.div_step) begin
         p_in   = qbit ? OpW'(pp - {1'b0, r1_ff}) : OpW'(pp);
         d_in   = {d_ff[OpW-2:0], 1'b0};
         t_in   = {t_ff[WORD_BITS-2:0], 1'b0} + (qbit ? s1_ff : '0);
         cnt_in = cnt_ff + CntW'(1);
      end
      if (cmd.div_finish) begin
         r0_in = r1_ff; r1_in = p_ff;
         s0_in = s1_ff; s1_in = s0_ff - t_ff;
      end
      if (cmd.finalize)
         inv_in = s_fix[OpW-1:0];
   end

   always_ff @(posedge clock) begin
      r0_ff <= r0_in; r1_ff <= r1_in; m_ff <= m_in;
      s0_ff <= s0_in; s1_ff <= s1_in;
      p_ff <= p_in; d_ff <= d_in; t_ff <= t_in; cnt_ff <= cnt_in;
      inv_ff <= inv_in;
   end

   assign status.r1_zero  = (r1_ff == '0);
   assign status.q_small  = ({1'b0, r0_ff} < twice_r1);
   assign status.div_last = (cnt_ff == CntW'(WORD_BITS - 2));
   assign rsp_inverse     = inv_ff;
endmodule

// File: src/modinv_ctrl.sv
module modinv_ctrl import modinv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (status.r1_zero) begin
               cmd.finalize = 1'b1;
               state_in     = ST_OUT;
            end else if (status.q_small) begin
               cmd.fast_step = 1'b1;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_DIV_END;
         end
         ST_DIV_END: begin
            cmd.div_finish = 1'b1;
            state_in       = ST_ROUND;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// File: src/modinv_checker.sv
module modinv_checker #(
   parameter int WORD_BITS = 64
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [WORD_BITS-2:0] rsp_inverse
);
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item taken while busy");
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_inverse)))
      else $error("stalled result changed");
endmodule

bind modular_inverse_top modinv_checker #(.WORD_BITS(WORD_BITS)) u_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_inverse
);
